[rtl/msr_pkg.sv]
`default_nettype none

package msr_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(WORD_WIDTH + 1);
  localparam int unsigned ZCAP_SHIFT = (WORD_WIDTH + 1) / 2;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Largest candidate tried in the non-residue search.
  localparam word_t ZCAP = word_t'(1) << ZCAP_SHIFT;

  typedef struct packed {
    word_t value;
    word_t modulus;
  } msr_in_t;

  typedef struct packed {
    word_t root;
    logic  no_root;
  } msr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_POW,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_TWOS,
    ST_ZTRY,
    ST_TLOOP,
    ST_SEARCH,
    ST_SEARCH_SQ,
    ST_BSQ,
    ST_BSQ_W,
    ST_CSQ,
    ST_TMUL,
    ST_RMUL,
    ST_DONE
  } state_e;

  // What a finished exponentiation feeds.
  typedef enum logic [2:0] {
    PW_EULER,
    PW_SONE,
    PW_ZTEST,
    PW_C,
    PW_T,
    PW_R
  } pow_e;

endpackage

`default_nettype wire

[rtl/msr_mulmod.sv]
`default_nettype none

// Bit-serial modular multiplier: one bit of b per cycle, most significant first.
// Operands must be below p; the result is a*b mod p.
module msr_mulmod (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire msr_pkg::word_t  a_i,
  input  wire msr_pkg::word_t  b_i,
  input  wire msr_pkg::word_t  p_i,
  output logic                 done_o,
  output msr_pkg::word_t       res_o
);

  localparam int unsigned W = msr_pkg::WORD_WIDTH;

  logic            run_q, run_d;
  logic            done_q, done_d;
  msr_pkg::cnt_t   cnt_q, cnt_d;
  msr_pkg::word_t  r_q, r_d;
  msr_pkg::word_t  a_q, a_d;
  msr_pkg::word_t  b_q, b_d;

  logic [W+1:0] sum;
  logic [W+1:0] p1;
  logic [W+1:0] p2;
  logic [W+1:0] red;

  // 2r + a stays below 3p, so at most two subtractions of p are needed.
  always_comb begin
    p1  = {2'b00, p_i};
    p2  = {1'b0, p_i, 1'b0};
    sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : {(W + 2){1'b0}});
    if (sum >= p2) begin
      red = sum - p2;
    end else if (sum >= p1) begin
      red = sum - p1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = msr_pkg::cnt_t'(W);
      r_d   = '0;
      a_d   = a_i;
      b_d   = b_i;
    end else if (run_q) begin
      r_d   = red[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - msr_pkg::cnt_t'(1);
      if (cnt_q == msr_pkg::cnt_t'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && run_q))
    else $error("multiplier started while busy");

  a_done_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q))
    else $error("multiplier done without a running operation");

  a_run_done_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && run_q))
    else $error("multiplier done while still running");

endmodule

`default_nettype wire

[rtl/modular_square_root.sv]
// Each modular multiply runs in one shared bit-serial unit.
// An exponentiation needs up to 2*WORD_WIDTH multiplies; an item runs at most four of
// them plus the non-residue search and the Tonelli-Shanks squaring loop.
// Items are handled one at a time; an item is shortest for modulus 0 or 2 and longest
// when an odd composite modulus runs the non-residue search to its cap.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle.
`default_nettype none

module modular_square_root (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire msr_pkg::msr_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output msr_pkg::msr_out_t       out_data_o
);

  localparam msr_pkg::word_t ONE = msr_pkg::word_t'(1);
  localparam msr_pkg::cnt_t  CONE = msr_pkg::cnt_t'(1);

  msr_pkg::state_e   state_q, state_d;
  msr_pkg::pow_e     purpose_q, purpose_d;
  logic              mul_start_q, mul_start_d;
  msr_pkg::word_t    mul_a_q, mul_a_d;
  msr_pkg::word_t    mul_b_q, mul_b_d;
  logic              mul_done;
  msr_pkg::word_t    mul_res;

  msr_pkg::word_t    n_q, n_d;
  msr_pkg::word_t    p_q, p_d;
  msr_pkg::word_t    exp_q, exp_d;
  msr_pkg::word_t    base_q, base_d;
  msr_pkg::word_t    acc_q, acc_d;
  msr_pkg::word_t    oddq_q, oddq_d;
  msr_pkg::word_t    z_q, z_d;
  msr_pkg::word_t    c_q, c_d;
  msr_pkg::word_t    t_q, t_d;
  msr_pkg::word_t    r_q, r_d;
  msr_pkg::word_t    tmp_q, tmp_d;
  msr_pkg::word_t    bb_q, bb_d;
  msr_pkg::cnt_t     s_q, s_d;
  msr_pkg::cnt_t     m_q, m_d;
  msr_pkg::cnt_t     i_q, i_d;
  msr_pkg::cnt_t     j_q, j_d;
  msr_pkg::word_t    root_q, root_d;
  logic              fail_q, fail_d;
  logic              out_valid_q, out_valid_d;
  msr_pkg::msr_out_t out_q, out_d;

  msr_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .p_i     (p_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_comb begin
    state_d     = state_q;
    purpose_d   = purpose_q;
    mul_start_d = 1'b0;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    n_d         = n_q;
    p_d         = p_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    oddq_d      = oddq_q;
    z_d         = z_q;
    c_d         = c_q;
    t_d         = t_q;
    r_d         = r_q;
    tmp_d       = tmp_q;
    bb_d        = bb_q;
    s_d         = s_q;
    m_d         = m_q;
    i_d         = i_q;
    j_d         = j_q;
    root_d      = root_q;
    fail_d      = fail_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      msr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          n_d    = in_data_i.value;
          p_d    = in_data_i.modulus;
          root_d = '0;
          fail_d = 1'b0;
          if (in_data_i.modulus == '0) begin
            state_d = msr_pkg::ST_DONE;
          end else if (in_data_i.modulus == msr_pkg::word_t'(2)) begin
            root_d  = {{(msr_pkg::WORD_WIDTH - 1){1'b0}}, in_data_i.value[0]};
            state_d = msr_pkg::ST_DONE;
          end else begin
            // 1 * n through the multiplier reduces n modulo p.
            mul_start_d = 1'b1;
            mul_a_d     = ONE;
            mul_b_d     = in_data_i.value;
            state_d     = msr_pkg::ST_REDUCE;
          end
        end
      end

      msr_pkg::ST_REDUCE: begin
        if (mul_done) begin
          n_d = mul_res;
          if (mul_res == '0) begin
            state_d = msr_pkg::ST_DONE;
          end else if (!p_q[0]) begin
            fail_d  = 1'b1;
            state_d = msr_pkg::ST_DONE;
          end else begin
            acc_d     = ONE;
            base_d    = mul_res;
            exp_d     = (p_q - ONE) >> 1;
            purpose_d = msr_pkg::PW_EULER;
            state_d   = msr_pkg::ST_POW;
          end
        end
      end

      msr_pkg::ST_POW: begin
        if (exp_q == '0) begin
          case (purpose_q)
            msr_pkg::PW_EULER: begin
              if (acc_q != ONE) begin
                fail_d  = 1'b1;
                state_d = msr_pkg::ST_DONE;
              end else begin
                oddq_d  = p_q - ONE;
                s_d     = '0;
                state_d = msr_pkg::ST_TWOS;
              end
            end
            msr_pkg::PW_SONE: begin
              root_d  = acc_q;
              state_d = msr_pkg::ST_DONE;
            end
            msr_pkg::PW_ZTEST: begin
              if (acc_q == p_q - ONE) begin
                m_d       = s_q;
                acc_d     = ONE;
                base_d    = z_q;
                exp_d     = oddq_q;
                purpose_d = msr_pkg::PW_C;
                state_d   = msr_pkg::ST_POW;
              end else begin
                z_d     = z_q + ONE;
                state_d = msr_pkg::ST_ZTRY;
              end
            end
            msr_pkg::PW_C: begin
              c_d       = acc_q;
              acc_d     = ONE;
              base_d    = n_q;
              exp_d     = oddq_q;
              purpose_d = msr_pkg::PW_T;
            end
            msr_pkg::PW_T: begin
              t_d       = acc_q;
              acc_d     = ONE;
              base_d    = n_q;
              exp_d     = (oddq_q >> 1) + ONE;
              purpose_d = msr_pkg::PW_R;
            end
            msr_pkg::PW_R: begin
              r_d     = acc_q;
              state_d = msr_pkg::ST_TLOOP;
            end
            default: begin
              state_d = msr_pkg::ST_IDLE;
            end
          endcase
        end else if (exp_q[0]) begin
          mul_start_d = 1'b1;
          mul_a_d     = acc_q;
          mul_b_d     = base_q;
          state_d     = msr_pkg::ST_POW_MUL;
        end else begin
          mul_start_d = 1'b1;
          mul_a_d     = base_q;
          mul_b_d     = base_q;
          state_d     = msr_pkg::ST_POW_SQ;
        end
      end

      msr_pkg::ST_POW_MUL: begin
        if (mul_done) begin
          acc_d = mul_res;
          if ((exp_q >> 1) == '0) begin
            // Last exponent bit: the final squaring of the base is not needed.
            exp_d   = '0;
            state_d = msr_pkg::ST_POW;
          end else begin
            mul_start_d = 1'b1;
            mul_a_d     = base_q;
            mul_b_d     = base_q;
            state_d     = msr_pkg::ST_POW_SQ;
          end
        end
      end

      msr_pkg::ST_POW_SQ: begin
        if (mul_done) begin
          base_d  = mul_res;
          exp_d   = exp_q >> 1;
          state_d = msr_pkg::ST_POW;
        end
      end

      msr_pkg::ST_TWOS: begin
        if (!oddq_q[0]) begin
          oddq_d = oddq_q >> 1;
          s_d    = s_q + CONE;
        end else if (s_q == CONE) begin
          acc_d     = ONE;
          base_d    = n_q;
          exp_d     = (p_q >> 2) + ONE;
          purpose_d = msr_pkg::PW_SONE;
          state_d   = msr_pkg::ST_POW;
        end else begin
          z_d     = msr_pkg::word_t'(2);
          state_d = msr_pkg::ST_ZTRY;
        end
      end

      msr_pkg::ST_ZTRY: begin
        if (z_q < p_q && z_q <= msr_pkg::ZCAP) begin
          acc_d     = ONE;
          base_d    = z_q;
          exp_d     = (p_q - ONE) >> 1;
          purpose_d = msr_pkg::PW_ZTEST;
          state_d   = msr_pkg::ST_POW;
        end else begin
          fail_d  = 1'b1;
          state_d = msr_pkg::ST_DONE;
        end
      end

      msr_pkg::ST_TLOOP: begin
        if (t_q == ONE) begin
          root_d  = r_q;
          state_d = msr_pkg::ST_DONE;
        end else begin
          i_d     = '0;
          tmp_d   = t_q;
          state_d = msr_pkg::ST_SEARCH;
        end
      end

      msr_pkg::ST_SEARCH: begin
        if (tmp_q != ONE && i_q < m_q) begin
          mul_start_d = 1'b1;
          mul_a_d     = tmp_q;
          mul_b_d     = tmp_q;
          state_d     = msr_pkg::ST_SEARCH_SQ;
        end else if (tmp_q != ONE) begin
          fail_d  = 1'b1;
          state_d = msr_pkg::ST_DONE;
        end else begin
          bb_d    = c_q;
          j_d     = i_q + CONE;
          state_d = msr_pkg::ST_BSQ;
        end
      end

      msr_pkg::ST_SEARCH_SQ: begin
        if (mul_done) begin
          tmp_d   = mul_res;
          i_d     = i_q + CONE;
          state_d = msr_pkg::ST_SEARCH;
        end
      end

      msr_pkg::ST_BSQ: begin
        if (j_q < m_q) begin
          mul_start_d = 1'b1;
          mul_a_d     = bb_q;
          mul_b_d     = bb_q;
          state_d     = msr_pkg::ST_BSQ_W;
        end else begin
          m_d         = i_q;
          mul_start_d = 1'b1;
          mul_a_d     = bb_q;
          mul_b_d     = bb_q;
          state_d     = msr_pkg::ST_CSQ;
        end
      end

      msr_pkg::ST_BSQ_W: begin
        if (mul_done) begin
          bb_d    = mul_res;
          j_d     = j_q + CONE;
          state_d = msr_pkg::ST_BSQ;
        end
      end

      msr_pkg::ST_CSQ: begin
        if (mul_done) begin
          c_d         = mul_res;
          mul_start_d = 1'b1;
          mul_a_d     = t_q;
          mul_b_d     = mul_res;
          state_d     = msr_pkg::ST_TMUL;
        end
      end

      msr_pkg::ST_TMUL: begin
        if (mul_done) begin
          t_d         = mul_res;
          mul_start_d = 1'b1;
          mul_a_d     = r_q;
          mul_b_d     = bb_q;
          state_d     = msr_pkg::ST_RMUL;
        end
      end

      msr_pkg::ST_RMUL: begin
        if (mul_done) begin
          r_d     = mul_res;
          state_d = msr_pkg::ST_TLOOP;
        end
      end

      msr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_d.root    = fail_q ? '0 : root_q;
          out_d.no_root = fail_q;
          state_d       = msr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = msr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msr_pkg::ST_IDLE;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_start_q <= mul_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    purpose_q <= purpose_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    n_q       <= n_d;
    p_q       <= p_d;
    exp_q     <= exp_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    oddq_q    <= oddq_d;
    z_q       <= z_d;
    c_q       <= c_d;
    t_q       <= t_d;
    r_q       <= r_d;
    tmp_q     <= tmp_d;
    bb_q      <= bb_d;
    s_q       <= s_d;
    m_q       <= m_d;
    i_q       <= i_d;
    j_q       <= j_d;
    root_q    <= root_d;
    fail_q    <= fail_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == msr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_root_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.no_root && out_data_o.root != '0))
    else $error("no_root result carries a nonzero root");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == msr_pkg::ST_REDUCE || state_q == msr_pkg::ST_POW_MUL ||
                  state_q == msr_pkg::ST_POW_SQ || state_q == msr_pkg::ST_SEARCH_SQ ||
                  state_q == msr_pkg::ST_BSQ_W || state_q == msr_pkg::ST_CSQ ||
                  state_q == msr_pkg::ST_TMUL || state_q == msr_pkg::ST_RMUL))
    else $error("multiplier result arrived outside a waiting state");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == msr_pkg::ST_DONE))
    else $error("result published outside the done state");

endmodule

`default_nettype wire
